FILE: src/gpi_lp_pkg.sv
`timescale 1ns / 1ps

package gpi_lp_pkg;

    // one line byte
    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_last;
    } t_gpi_in;

    // one verdict
    typedef struct packed {
        logic       accepted;
        logic [2:0] channel;
        logic [2:0] pin;
        logic       level;
    } t_gpi_out;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'd0,
        PH_PFX1   = 4'd1,
        PH_PFX2   = 4'd2,
        PH_PFX3   = 4'd3,
        PH_NUMWS  = 4'd4,
        PH_DIGITS = 4'd5,
        PH_SEPWS  = 4'd6,
        PH_PAD    = 4'd7,
        PH_DONE   = 4'd8,
        PH_FAIL   = 4'd9
    } t_phase;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UP_H  = 8'h48;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_UP_L  = 8'h4C;
    localparam logic [7:0] CH_LO_L  = 8'h6C;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // expected byte in each prefix phase ("GPI " after the G)
    function automatic logic [7:0] prefix_char(input t_phase ph);
        logic [7:0] r;
        r = CH_SPACE;
        unique case (ph)
            PH_PFX1: r = CH_P;
            PH_PFX2: r = CH_I;
            default: r = CH_SPACE;
        endcase
        return r;
    endfunction

endpackage

FILE: src/gpi_lp_core.sv
`timescale 1ns / 1ps

module gpi_lp_core #(
    parameter int MAX_CHANNEL = 4,
    parameter int MAX_PIN     = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  gpi_lp_pkg::t_gpi_in  i_data,
    output logic                 o_push,
    output gpi_lp_pkg::t_gpi_out o_result
);

    localparam int NUM_W = $clog2(MAX_CHANNEL + 2);
    localparam int PIN_W = $clog2(MAX_PIN + 2);
    localparam int SUM_W = NUM_W + 4;

    localparam logic [NUM_W-1:0] NUM_SAT = NUM_W'(MAX_CHANNEL + 1);
    localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(MAX_CHANNEL);
    localparam logic [PIN_W-1:0] PIN_MAX = PIN_W'(MAX_PIN);
    localparam logic [PIN_W-1:0] PIN_ONE = PIN_W'(1);

    gpi_lp_pkg::t_phase r_phase, n_phase;
    logic [NUM_W-1:0]   r_num, n_num;
    logic               r_neg, n_neg;
    logic               r_dig, n_dig;
    logic [PIN_W-1:0]   r_pin, n_pin;
    logic               r_lvl, n_lvl;

    logic [7:0]       c;
    logic             c_ws;
    logic             c_digit;
    logic             do_digits;
    logic             do_sep;
    logic             do_pad;
    logic [SUM_W-1:0] sum;

    assign c       = i_data.text_byte;
    assign c_ws    = gpi_lp_pkg::is_ws(c);
    assign c_digit = (c >= gpi_lp_pkg::CH_ZERO) && (c <= gpi_lp_pkg::CH_NINE);
    // digits sit at 0x30..0x39, so the low nibble is the value
    assign sum     = (SUM_W'(r_num) << 3) + (SUM_W'(r_num) << 1) + SUM_W'(c[3:0]);

    always_comb begin
        n_phase   = r_phase;
        n_num     = r_num;
        n_neg     = r_neg;
        n_dig     = r_dig;
        n_pin     = r_pin;
        n_lvl     = r_lvl;
        do_digits = 1'b0;
        do_sep    = 1'b0;
        do_pad    = 1'b0;

        if ((r_phase == gpi_lp_pkg::PH_DONE) || (r_phase == gpi_lp_pkg::PH_FAIL)) begin
            n_phase = r_phase;
        end else if (c == gpi_lp_pkg::CH_NUL) begin
            n_phase = gpi_lp_pkg::PH_FAIL;
        end else begin
            unique case (r_phase)
                gpi_lp_pkg::PH_LEAD: begin
                    if (!c_ws) begin
                        n_phase = (c == gpi_lp_pkg::CH_G) ? gpi_lp_pkg::PH_PFX1
                                                          : gpi_lp_pkg::PH_FAIL;
                    end
                end
                gpi_lp_pkg::PH_PFX1, gpi_lp_pkg::PH_PFX2, gpi_lp_pkg::PH_PFX3: begin
                    if (c != gpi_lp_pkg::prefix_char(r_phase)) begin
                        n_phase = gpi_lp_pkg::PH_FAIL;
                    end else begin
                        n_phase = gpi_lp_pkg::t_phase'(r_phase + 4'd1);
                    end
                end
                gpi_lp_pkg::PH_NUMWS: begin
                    if (c == gpi_lp_pkg::CH_PLUS || c == gpi_lp_pkg::CH_MINUS) begin
                        n_neg   = (c == gpi_lp_pkg::CH_MINUS);
                        n_phase = gpi_lp_pkg::PH_DIGITS;
                    end else if (!c_ws) begin
                        do_digits = 1'b1;
                    end
                end
                gpi_lp_pkg::PH_DIGITS: do_digits = 1'b1;
                gpi_lp_pkg::PH_SEPWS:  do_sep    = 1'b1;
                gpi_lp_pkg::PH_PAD:    do_pad    = 1'b1;
                default:               n_phase   = gpi_lp_pkg::PH_FAIL;
            endcase

            if (do_digits) begin
                n_phase = gpi_lp_pkg::PH_DIGITS;
                if (c_digit) begin
                    n_num = (sum > SUM_W'(NUM_SAT)) ? NUM_SAT : NUM_W'(sum);
                    n_dig = 1'b1;
                end else if (!r_dig || r_neg || r_num == '0 || r_num > NUM_MAX) begin
                    n_phase = gpi_lp_pkg::PH_FAIL;
                end else begin
                    do_sep = 1'b1;
                end
            end

            if (do_sep) begin
                if (c_ws) begin
                    n_phase = gpi_lp_pkg::PH_SEPWS;
                end else begin
                    do_pad = 1'b1;
                end
            end

            if (do_pad) begin
                n_phase = gpi_lp_pkg::PH_PAD;
                if (c == gpi_lp_pkg::CH_X) begin
                    if (r_pin <= PIN_MAX) begin
                        n_pin = r_pin + PIN_ONE;
                    end
                end else if (r_pin > PIN_MAX) begin
                    n_phase = gpi_lp_pkg::PH_FAIL;
                end else if (c == gpi_lp_pkg::CH_UP_H || c == gpi_lp_pkg::CH_LO_H) begin
                    n_lvl   = 1'b1;
                    n_phase = gpi_lp_pkg::PH_DONE;
                end else if (c == gpi_lp_pkg::CH_UP_L || c == gpi_lp_pkg::CH_LO_L) begin
                    n_lvl   = 1'b0;
                    n_phase = gpi_lp_pkg::PH_DONE;
                end else begin
                    n_phase = gpi_lp_pkg::PH_FAIL;
                end
            end
        end
    end

    // verdict comes from the state after the final byte
    always_comb begin
        o_push   = i_take && i_data.line_last;
        o_result = '0;
        if (n_phase == gpi_lp_pkg::PH_DONE) begin
            o_result.accepted = 1'b1;
            o_result.channel  = 3'(n_num);
            o_result.pin      = 3'(n_pin);
            o_result.level    = n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gpi_lp_pkg::PH_LEAD;
            r_num   <= '0;
            r_neg   <= 1'b0;
            r_dig   <= 1'b0;
            r_pin   <= PIN_ONE;
            r_lvl   <= 1'b0;
        end else if (i_take) begin
            if (i_data.line_last) begin
                r_phase <= gpi_lp_pkg::PH_LEAD;
                r_num   <= '0;
                r_neg   <= 1'b0;
                r_dig   <= 1'b0;
                r_pin   <= PIN_ONE;
                r_lvl   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_num   <= n_num;
                r_neg   <= n_neg;
                r_dig   <= n_dig;
                r_pin   <= n_pin;
                r_lvl   <= n_lvl;
            end
        end
    end

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_data.line_last) |=> (r_phase == gpi_lp_pkg::PH_LEAD && r_pin == PIN_ONE
                                          && r_num == '0 && !r_dig))
        else $error("parser state not cleared after final byte");

    a_accept_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_result.accepted) |-> (o_result.channel != 3'd0 && o_result.pin != 3'd0))
        else $error("accepted verdict with zero channel or pin");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !o_result.accepted) |-> (o_result.channel == 3'd0 && o_result.pin == 3'd0
                                            && !o_result.level))
        else $error("rejected verdict carries nonzero fields");

    a_pin_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pin >= PIN_ONE) && (r_pin <= PIN_MAX + PIN_ONE))
        else $error("pin counter outside its saturating range");

endmodule

FILE: src/gpi_lp_obuf.sv
`timescale 1ns / 1ps

module gpi_lp_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  gpi_lp_pkg::t_gpi_out i_data,
    output logic                 o_room,
    output logic                 o_valid,
    output gpi_lp_pkg::t_gpi_out o_data,
    input  logic                 i_ready
);

    logic                 r_main_valid;
    logic                 r_skid_valid;
    gpi_lp_pkg::t_gpi_out r_main;
    gpi_lp_pkg::t_gpi_out r_skid;
    logic                 pop;

    assign pop     = r_main_valid && i_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    // payload moves without reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

FILE: src/gpi_line_parser.sv
`timescale 1ns / 1ps

// Parses general-purpose-input report lines ("GPI <channel> x..x<H|L>") one byte
// per cycle: a byte is taken every clock while the output side keeps up, and the
// verdict for a line is registered into the main or skid entry of the output
// buffer as its final byte is transferred. The per-byte parse is a single pass
// of logic on the parser state registers; a two-entry output buffer holds up to
// two verdicts, so input keeps flowing while one verdict waits and stalls only
// while both entries are full, until the older verdict is taken.
module gpi_line_parser #(
    parameter int MAX_CHANNEL = 4,
    parameter int MAX_PIN     = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gpi_lp_pkg::t_gpi_in  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gpi_lp_pkg::t_gpi_out o_out_data
);

    logic                 take;
    logic                 push;
    logic                 room;
    gpi_lp_pkg::t_gpi_out result;

    assign o_in_ready = room;
    assign take       = i_in_valid && room;

    gpi_lp_core #(
        .MAX_CHANNEL(MAX_CHANNEL),
        .MAX_PIN    (MAX_PIN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_in_data),
        .o_push  (push),
        .o_result(result)
    );

    gpi_lp_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (result),
        .o_room (room),
        .o_valid(o_out_valid),
        .o_data (o_out_data),
        .i_ready(i_out_ready)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int MAX_CHANNEL  = 4;
    localparam int MAX_PIN      = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHOW_LIMIT   = 10;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    gpi_lp_pkg::t_gpi_in  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    gpi_lp_pkg::t_gpi_out out_data;

    bit gaps_on    = 1'b1;
    int cycle_cnt  = 0;
    int bytes_sent = 0;
    int lines_sent = 0;
    int verdicts_seen = 0;
    int reports_seen  = 0;
    int mismatches    = 0;

    // shadow of the line parser
    gpi_lp_pkg::t_phase ph = gpi_lp_pkg::PH_LEAD;
    int     num_val = 0;
    bit     num_neg = 1'b0;
    bit     num_dig = 1'b0;
    int     pin_cnt = 1;
    bit     lvl     = 1'b0;

    gpi_lp_pkg::t_gpi_out verdicts_due[$];
    logic [7:0]           line_buf[$];

    gpi_line_parser #(
        .MAX_CHANNEL (MAX_CHANNEL),
        .MAX_PIN     (MAX_PIN)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb: timeout after %0d cycles, %0d verdicts pending", cycle_cnt,
                 verdicts_due.size());
        $display("tb: done, errors");
        $finish;
    end

    function automatic bit blank(input logic [7:0] c);
        return (c == gpi_lp_pkg::CH_SPACE) ||
               (c inside {[gpi_lp_pkg::CH_TAB:gpi_lp_pkg::CH_CR]});
    endfunction

    function automatic void clear_parse();
        ph      = gpi_lp_pkg::PH_LEAD;
        num_val = 0;
        num_neg = 1'b0;
        num_dig = 1'b0;
        pin_cnt = 1;
        lvl     = 1'b0;
    endfunction

    // advance the shadow parser by one character
    function automatic void parse_char(input logic [7:0] c);
        gpi_lp_pkg::t_phase stage;
        int                 v;
        if (ph == gpi_lp_pkg::PH_DONE || ph == gpi_lp_pkg::PH_FAIL)
            return;
        if (c == gpi_lp_pkg::CH_NUL) begin
            ph = gpi_lp_pkg::PH_FAIL;
            return;
        end
        case (ph)
            gpi_lp_pkg::PH_LEAD: begin
                if (!blank(c))
                    ph = (c == gpi_lp_pkg::CH_G) ? gpi_lp_pkg::PH_PFX1 : gpi_lp_pkg::PH_FAIL;
                return;
            end
            gpi_lp_pkg::PH_PFX1: begin
                ph = (c == gpi_lp_pkg::CH_P) ? gpi_lp_pkg::PH_PFX2 : gpi_lp_pkg::PH_FAIL;
                return;
            end
            gpi_lp_pkg::PH_PFX2: begin
                ph = (c == gpi_lp_pkg::CH_I) ? gpi_lp_pkg::PH_PFX3 : gpi_lp_pkg::PH_FAIL;
                return;
            end
            gpi_lp_pkg::PH_PFX3: begin
                ph = (c == gpi_lp_pkg::CH_SPACE) ? gpi_lp_pkg::PH_NUMWS
                                                 : gpi_lp_pkg::PH_FAIL;
                return;
            end
            default: ;
        endcase
        stage = ph;
        if (stage == gpi_lp_pkg::PH_NUMWS) begin
            if (blank(c))
                return;
            if (c == gpi_lp_pkg::CH_PLUS || c == gpi_lp_pkg::CH_MINUS) begin
                num_neg = (c == gpi_lp_pkg::CH_MINUS);
                ph = gpi_lp_pkg::PH_DIGITS;
                return;
            end
            stage = gpi_lp_pkg::PH_DIGITS;
            ph    = gpi_lp_pkg::PH_DIGITS;
        end
        if (stage == gpi_lp_pkg::PH_DIGITS) begin
            if (c >= gpi_lp_pkg::CH_ZERO && c <= gpi_lp_pkg::CH_NINE) begin
                v = num_val * 10 + int'(c - gpi_lp_pkg::CH_ZERO);
                num_val = (v > MAX_CHANNEL + 1) ? MAX_CHANNEL + 1 : v;
                num_dig = 1'b1;
                return;
            end
            if (!num_dig || num_neg || num_val < 1 || num_val > MAX_CHANNEL) begin
                ph = gpi_lp_pkg::PH_FAIL;
                return;
            end
            // whitespace right after the digits is skipped
            stage = gpi_lp_pkg::PH_SEPWS;
            ph    = gpi_lp_pkg::PH_SEPWS;
        end
        if (stage == gpi_lp_pkg::PH_SEPWS) begin
            if (blank(c))
                return;
            ph = gpi_lp_pkg::PH_PAD;
        end
        if (c == gpi_lp_pkg::CH_X) begin
            if (pin_cnt <= MAX_PIN)
                pin_cnt++;
            return;
        end
        if (pin_cnt > MAX_PIN)
            ph = gpi_lp_pkg::PH_FAIL;
        else if (c == gpi_lp_pkg::CH_UP_H || c == gpi_lp_pkg::CH_LO_H) begin
            lvl = 1'b1;
            ph  = gpi_lp_pkg::PH_DONE;
        end else if (c == gpi_lp_pkg::CH_UP_L || c == gpi_lp_pkg::CH_LO_L) begin
            lvl = 1'b0;
            ph  = gpi_lp_pkg::PH_DONE;
        end else
            ph = gpi_lp_pkg::PH_FAIL;
    endfunction

    function automatic void close_line();
        gpi_lp_pkg::t_gpi_out v;
        v = '0;
        if (ph == gpi_lp_pkg::PH_DONE) begin
            v.accepted = 1'b1;
            v.channel  = 3'(num_val);
            v.pin      = 3'(pin_cnt);
            v.level    = lvl;
        end
        verdicts_due.push_back(v);
        clear_parse();
    endfunction

    // verdict side: random backpressure and in-order compare
    always @(posedge clk) begin : check_verdicts
        gpi_lp_pkg::t_gpi_out want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("tb: verdict with none pending: %b at cycle %0d",
                             out_data, cycle_cnt);
            end else begin
                want = verdicts_due.pop_front();
                if (want.accepted)
                    reports_seen++;
                if (out_data.accepted !== want.accepted || out_data.channel !== want.channel ||
                    out_data.pin !== want.pin || out_data.level !== want.level) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"tb: verdict %0d expected acc=%b ch=%0d pin=%0d lvl=%b, ",
                                  "got acc=%b ch=%0d pin=%0d lvl=%b"}, verdicts_seen,
                                 want.accepted, want.channel, want.pin, want.level,
                                 out_data.accepted, out_data.channel, out_data.pin,
                                 out_data.level);
                end
            end
        end
        out_ready <= !(gaps_on && $urandom_range(99) < 19);
    end

    task automatic send_byte(input logic [7:0] c, input logic last);
        gpi_lp_pkg::t_gpi_in item;
        item.text_byte = c;
        item.line_last = last;
        if (gaps_on && $urandom_range(99) < 19) begin
            in_valid <= 1'b0;
            do @(posedge clk); while (gaps_on && $urandom_range(99) < 19);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_ready !== 1'b1);
        bytes_sent++;
        parse_char(c);
        if (last) begin
            lines_sent++;
            close_line();
        end
    endtask

    task automatic send_line();
        if (line_buf.size() == 0)
            line_buf.push_back(gpi_lp_pkg::CH_SPACE);
        for (int k = 0; k < line_buf.size(); k++)
            send_byte(line_buf[k], k == line_buf.size() - 1);
        line_buf.delete();
    endtask

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endfunction

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(5);
        return (k == 0) ? gpi_lp_pkg::CH_SPACE : gpi_lp_pkg::CH_TAB + 8'(k - 1);
    endfunction

    task automatic send_text(input string s);
        add_text(s);
        send_line();
    endtask

    task automatic test_well_formed();
        send_text("GPI 1H");
        send_text("  \t GPI 4xxxxl");
        send_text("GPI +2 xxh");
        line_buf.push_back(gpi_lp_pkg::CH_TAB);
        add_text("GPI 004");
        line_buf.push_back(gpi_lp_pkg::CH_CR);
        add_text("xL");
        send_line();
        send_text("GPI 2xH and more");
    endtask

    task automatic test_rejects();
        send_text("GPI -1H");
        send_text("GPI 0H");
        send_text("GPI 5H");
        send_text("GPI 99999xL");
        send_text("GPI +H");
        send_text("GPI  xH");
        send_text("GPI - 1H");
        send_text("GPI 3xx H");
        send_text("GPI 3xxxxxH");
        send_text("GPI 2xx");
        send_text("GPx 1H");
        send_text("gpi 1H");
        send_text("GPI\t1H");
        line_buf.push_back(8'hFF);
        send_line();
    endtask

    task automatic test_zero_byte();
        add_text("GPI 2");
        line_buf.push_back(gpi_lp_pkg::CH_NUL);
        add_text("xH");
        send_line();
        // zero after the level leaves the verdict intact
        add_text("GPI 3xL");
        line_buf.push_back(gpi_lp_pkg::CH_NUL);
        add_text("zz");
        send_line();
        line_buf.push_back(gpi_lp_pkg::CH_NUL);
        send_line();
    endtask

    // mostly well-formed report with random content, some of it broken
    task automatic build_report_line();
        int n;
        int r;
        repeat ($urandom_range(2)) line_buf.push_back(pick_blank());
        add_text("GPI ");
        if ($urandom_range(99) < 5)
            line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom);
        if ($urandom_range(99) < 10)
            line_buf.push_back(pick_blank());
        r = $urandom_range(99);
        if (r < 10)
            line_buf.push_back(gpi_lp_pkg::CH_PLUS);
        else if (r < 16)
            line_buf.push_back(gpi_lp_pkg::CH_MINUS);
        if ($urandom_range(99) < 4)
            line_buf.push_back(pick_blank());
        n = ($urandom_range(99) < 85) ? 1 : $urandom_range(3);
        for (int k = 0; k < n; k++) begin
            if (k == n - 1 && $urandom_range(99) < 85)
                line_buf.push_back(gpi_lp_pkg::CH_ZERO + 8'($urandom_range(MAX_CHANNEL, 1)));
            else if (k < n - 1 && $urandom_range(1) == 1)
                line_buf.push_back(gpi_lp_pkg::CH_ZERO);
            else
                line_buf.push_back(gpi_lp_pkg::CH_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(99) < 20)
            line_buf.push_back(pick_blank());
        n = ($urandom_range(99) < 90) ? $urandom_range(MAX_PIN - 1)
                                      : $urandom_range(MAX_PIN + 2, MAX_PIN);
        repeat (n) line_buf.push_back(gpi_lp_pkg::CH_X);
        if ($urandom_range(99) < 4)
            line_buf.push_back(pick_blank());
        r = $urandom_range(99);
        if (r < 24)
            line_buf.push_back(gpi_lp_pkg::CH_UP_H);
        else if (r < 48)
            line_buf.push_back(gpi_lp_pkg::CH_LO_H);
        else if (r < 72)
            line_buf.push_back(gpi_lp_pkg::CH_UP_L);
        else if (r < 96)
            line_buf.push_back(gpi_lp_pkg::CH_LO_L);
        else
            line_buf.push_back(8'($urandom));
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(4, 1)) line_buf.push_back(8'($urandom));
        if ($urandom_range(99) < 5)
            line_buf.insert($urandom_range(line_buf.size() - 1), gpi_lp_pkg::CH_NUL);
        if ($urandom_range(99) < 5) begin
            n = $urandom_range(line_buf.size(), 1);
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
        end
    endtask

    task automatic test_random_lines(input int budget);
        int stop_at;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 80)
                build_report_line();
            else
                repeat ($urandom_range(8, 1)) line_buf.push_back(8'($urandom));
            send_line();
        end
    endtask

    task automatic test_streaming(input int budget);
        gaps_on = 1'b0;
        test_random_lines(budget);
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_well_formed();
        test_rejects();
        test_zero_byte();
        test_random_lines(130);
        test_streaming(110);
        test_random_lines(130);
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d bytes in %0d lines sent, %0d verdicts checked, %0d accepted reports",
                 bytes_sent, lines_sent, verdicts_seen, reports_seen);
        $display("tb: %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
